@@ sv/pdpe_pkg.sv @@
package pdpe_pkg;

  localparam int PIN_SYMBOLS_DEF = 8;

  // Configuration register indexes and reset values.
  localparam logic [2:0] REG_LONG_PRESS  = 3'd0;
  localparam logic [2:0] REG_GAP_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_MIN_SYMBOLS = 3'd2;
  localparam logic [2:0] REG_CLASS_CODE  = 3'd3;
  localparam logic [2:0] REG_VERIFY_INS  = 3'd4;
  localparam logic [2:0] REG_SET_INS     = 3'd5;

  localparam logic [15:0] LONG_PRESS_RST  = 16'd500;
  localparam logic [15:0] GAP_TIMEOUT_RST = 16'd1500;
  localparam logic [3:0]  MIN_SYMBOLS_RST = 4'd4;
  localparam logic [7:0]  CLASS_CODE_RST  = 8'd0;
  localparam logic [7:0]  VERIFY_INS_RST  = 8'd1;
  localparam logic [7:0]  SET_INS_RST     = 8'd2;

  // Session kinds.
  localparam logic [1:0] SES_NONE       = 2'd0;
  localparam logic [1:0] SES_VERIFY     = 2'd1;
  localparam logic [1:0] SES_SET_CHECK  = 2'd2;
  localparam logic [1:0] SES_SET_UPDATE = 2'd3;

  // Button tracking phases.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_RELEASED = 2'd2;

  // Symbol codes; zero is an empty position.
  localparam logic [1:0] SYM_EMPTY = 2'd0;
  localparam logic [1:0] SYM_SHORT = 2'd1;
  localparam logic [1:0] SYM_LONG  = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CONFIRM = 3'd1;
  localparam logic [2:0] ST_VFAIL   = 3'd2;
  localparam logic [2:0] ST_NOPIN   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_BADINS  = 3'd6;
  localparam logic [2:0] ST_BADCLA  = 3'd7;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] gap_timeout_ms;
    logic [3:0]  min_symbols;
    logic [7:0]  class_code;
    logic [7:0]  verify_ins;
    logic [7:0]  set_ins;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic        button;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic       has_status;
    logic [2:0] status;
    logic       session_alive;
  } result_t;

endpackage

@@ sv/pdpe_engine.sv @@
module pdpe_engine
  import pdpe_pkg::*;
#(
  parameter int PIN_SYMBOLS = PIN_SYMBOLS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int IDXW = $clog2(PIN_SYMBOLS);
  localparam int CW   = $clog2(PIN_SYMBOLS + 1);
  localparam int MW   = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] COUNT_FULL = CW'(PIN_SYMBOLS);

  logic [1:0]                   session_type, session_type_next;
  logic [1:0]                   press_phase, press_phase_next;
  logic [PIN_SYMBOLS-1:0][1:0]  entered, entered_next;
  logic [PIN_SYMBOLS-1:0][1:0]  stored, stored_next;
  logic [CW-1:0]                symbol_count, symbol_count_next;
  logic [31:0]                  mark_time, mark_time_next;

  logic [31:0] dt;
  logic        over_gap;
  logic        long_hold;
  logic        pin_stored;
  logic        pin_match;
  logic        too_few;
  logic [1:0]  sym;

  assign dt         = item.now_ms - mark_time;
  assign over_gap   = dt > {16'd0, cfg.gap_timeout_ms};
  assign long_hold  = dt > {16'd0, cfg.long_press_ms};
  assign sym        = long_hold ? SYM_LONG : SYM_SHORT;
  assign pin_stored = (stored[0] == SYM_SHORT) || (stored[0] == SYM_LONG);
  assign pin_match  = (entered == stored);
  assign too_few    = MW'(symbol_count) < MW'(cfg.min_symbols);

  always_comb begin
    logic ev_timeout;
    logic ev_done;
    logic clear;

    session_type_next = session_type;
    press_phase_next  = press_phase;
    entered_next      = entered;
    stored_next       = stored;
    symbol_count_next = symbol_count;
    mark_time_next    = mark_time;
    res               = '0;
    ev_timeout        = 1'b0;
    ev_done           = 1'b0;
    clear             = 1'b0;

    if (item.kind) begin
      clear = 1'b1;
      if (item.cla != cfg.class_code) begin
        res.has_status = 1'b1;
        res.status     = ST_BADCLA;
      end else if (item.ins == cfg.verify_ins) begin
        if (pin_stored) begin
          res.session_alive = 1'b1;
        end else begin
          res.has_status = 1'b1;
          res.status     = ST_NOPIN;
        end
      end else if (item.ins == cfg.set_ins) begin
        res.session_alive = 1'b1;
      end else begin
        res.has_status = 1'b1;
        res.status     = ST_BADINS;
      end
    end else if (session_type != SES_NONE) begin
      res.session_alive = 1'b1;
      unique case (press_phase)
        PH_PRESSED: begin
          if (item.button) begin
            ev_timeout = over_gap;
          end else begin
            // Presses past the PIN length are dropped.
            if (symbol_count < COUNT_FULL) begin
              entered_next[symbol_count[IDXW-1:0]] = sym;
              symbol_count_next = symbol_count + 1'b1;
            end
            press_phase_next = PH_RELEASED;
            mark_time_next   = item.now_ms;
          end
        end
        PH_RELEASED: begin
          if (item.button) begin
            press_phase_next = PH_PRESSED;
            mark_time_next   = item.now_ms;
          end else if (over_gap) begin
            ev_timeout = too_few;
            ev_done    = !too_few;
          end
        end
        default: begin
          if (item.button) begin
            press_phase_next = PH_PRESSED;
            mark_time_next   = item.now_ms;
          end
        end
      endcase

      if (ev_timeout) begin
        res.has_status    = 1'b1;
        res.status        = ST_TIMEOUT;
        res.session_alive = 1'b0;
        clear             = 1'b1;
      end else if (ev_done) begin
        res.has_status = 1'b1;
        clear          = 1'b1;
        unique case (session_type)
          SES_VERIFY: begin
            res.status        = pin_match ? ST_CONFIRM : ST_VFAIL;
            res.session_alive = 1'b0;
          end
          SES_SET_CHECK: begin
            res.status        = pin_match ? ST_CONFIRM : ST_VFAIL;
            res.session_alive = pin_match;
          end
          default: begin
            stored_next       = entered;
            res.status        = ST_OK;
            res.session_alive = 1'b0;
          end
        endcase
      end
    end

    if (clear) begin
      press_phase_next  = PH_IDLE;
      entered_next      = '0;
      symbol_count_next = '0;
      mark_time_next    = '0;
      session_type_next = SES_NONE;
      if (item.kind && res.session_alive) begin
        if (item.ins == cfg.verify_ins) begin
          session_type_next = SES_VERIFY;
        end else begin
          session_type_next = pin_stored ? SES_SET_CHECK : SES_SET_UPDATE;
        end
      end else if (!item.kind && res.session_alive) begin
        // A confirmed old PIN moves on to taking the new one.
        session_type_next = SES_SET_UPDATE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_type <= SES_NONE;
      press_phase  <= PH_IDLE;
      entered      <= '0;
      stored       <= '0;
      symbol_count <= '0;
      mark_time    <= '0;
    end else if (fire) begin
      session_type <= session_type_next;
      press_phase  <= press_phase_next;
      entered      <= entered_next;
      stored       <= stored_next;
      symbol_count <= symbol_count_next;
      mark_time    <= mark_time_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    symbol_count <= COUNT_FULL)
    else $error("symbol count ran past the PIN length");

  a_idle_when_no_session: assert property (@(posedge clk) disable iff (rst)
    (session_type == SES_NONE) |-> (press_phase == PH_IDLE && symbol_count == '0))
    else $error("entry state left over without a session");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (fire && !res.has_status) |-> (res.status == ST_OK))
    else $error("status set without has_status");

  a_alive_with_status: assert property (@(posedge clk) disable iff (rst)
    (fire && res.has_status && res.session_alive) |-> (res.status == ST_CONFIRM))
    else $error("session goes on after a final status");

  a_request_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && item.kind) |=> (symbol_count == '0 && press_phase == PH_IDLE))
    else $error("request did not clear the entry");
`endif

endmodule

@@ sv/press_duration_pin_entry_top.sv @@
// Single-button PIN entry. A request item (tuser 1) starts a verify or a
// set-PIN session; poll items (tuser 0) carry the button level and the time
// in ms, and each poll or request yields exactly one result item with an
// optional status and a flag that says whether the session wants more polls.
// Items are taken at a rate of one item per clock as long as the result side
// keeps taking items: the input register feeds the state update, which does a
// parallel compare of the whole PIN, and the result lands in an output
// register. The PIN store lives in flip-flops and is cleared by reset.
// Configuration writes are taken at any time but should be made only while
// no item is in flight.
module press_duration_pin_entry_top
  import pdpe_pkg::*;
#(
  parameter int PIN_SYMBOLS = PIN_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // cla[7:0], ins[15:8], button[16], now_ms[48:17], zero
  input  logic        s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status[2:0], session_alive[3], zero
  output logic        m_tuser,   // has_status[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_v;
  result_t res;
  result_t out_res;
  logic    out_v;
  logic    adv;

  assign adv      = in_v && (!out_v || m_tready);
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms  <= LONG_PRESS_RST;
      cfg.gap_timeout_ms <= GAP_TIMEOUT_RST;
      cfg.min_symbols    <= MIN_SYMBOLS_RST;
      cfg.class_code     <= CLASS_CODE_RST;
      cfg.verify_ins     <= VERIFY_INS_RST;
      cfg.set_ins        <= SET_INS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS:  cfg.long_press_ms  <= cfg_data;
        REG_GAP_TIMEOUT: cfg.gap_timeout_ms <= cfg_data;
        REG_MIN_SYMBOLS: cfg.min_symbols    <= cfg_data[3:0];
        REG_CLASS_CODE:  cfg.class_code     <= cfg_data[7:0];
        REG_VERIFY_INS:  cfg.verify_ins     <= cfg_data[7:0];
        REG_SET_INS:     cfg.set_ins        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind   <= s_tuser;
      in_item.cla    <= s_tdata[7:0];
      in_item.ins    <= s_tdata[15:8];
      in_item.button <= s_tdata[16];
      in_item.now_ms <= s_tdata[48:17];
    end
  end

  pdpe_engine #(
    .PIN_SYMBOLS(PIN_SYMBOLS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tuser  = out_res.has_status;
  assign m_tdata  = {4'd0, out_res.session_alive, out_res.status};

endmodule
